[rtl/core/sevs_pkg.sv]
package sevs_pkg;

    // item kinds carried on the input tuser
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_PLAY   = 3'd1;
    localparam logic [2:0] ACT_STOP   = 3'd2;
    localparam logic [2:0] ACT_WR_LO  = 3'd3;
    localparam logic [2:0] ACT_WR_HI  = 3'd4;

    // voice register selects carried on the output tuser
    localparam logic [2:0] REG_FREQ   = 3'd0;
    localparam logic [2:0] REG_PWM    = 3'd1;
    localparam logic [2:0] REG_CTRL   = 3'd2;
    localparam logic [2:0] REG_ATTDEC = 3'd3;
    localparam logic [2:0] REG_SUSREL = 3'd4;
    localparam logic [2:0] REG_STATUS = 3'd5;

    // channel sequencing states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RESET   = 3'd1;
    localparam logic [2:0] ST_READY   = 3'd2;
    localparam logic [2:0] ST_PLAY    = 3'd3;
    localparam logic [2:0] ST_WAIT    = 3'd4;

    // entry masks
    localparam logic [7:0] CTRL_GATE   = 8'h01;
    localparam logic [7:0] ATTDEC_MASK = 8'hef;
    localparam logic [7:0] SUSREL_HI   = 8'hf0;

    // fixed sizes
    localparam int ENTRY_W     = 56;
    localparam int MAX_RESULTS = 64;
    localparam int RES_AW      = 6;
    localparam int RES_W       = 19;

    typedef logic [ENTRY_W-1:0] t_entry;

endpackage

[rtl/core/sevs_ram.sv]
module sevs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/sound_effect_voice_sequencer_unit.sv]
// Sound effect voice sequencer. Effect entries (two 56-bit words each) are
// written into two entry memories; play, stop and tick items then drive a
// per-channel sequencer that turns the entries into voice register writes.
// One input item is handled at a time. An item is first dispatched (transfer
// and entry memory read). A tick whose delay has not run out on an active
// effect then applies the frequency and pulse width sweeps. Each chained
// step of the channel reads its entry and then makes its register writes
// (reset three, ready five, otherwise at most one); a step that moves to the
// next entry also reads that entry, and retriggers the gate with two writes
// when needed. Results are collected in a 64-entry result memory and sent
// once the item is done: the item is closed, then each result is read,
// loaded and held until its output transfer, so any output stall holds it.
// The next item is taken after the final result transfer. There is no
// clearing pass after reset.
module sound_effect_voice_sequencer_unit #(
    parameter int NUM_CHANNELS = 3,
    parameter int EFFECT_SLOTS = 64,
    parameter int MAX_CHAIN    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // channel[1:0], entry_index[7:2], count[11:8], entry_data[67:12], zero pad
    input  logic [71:0] i_s_axis_tdata,
    // action[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // voice[1:0], value[17:2], channel_idle[18], remaining[21:19], zero pad
    output logic [23:0] o_m_axis_tdata,
    // reg_select[2:0]
    output logic [2:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    import sevs_pkg::*;

    localparam int SW = $clog2(EFFECT_SLOTS);
    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_SWF  = 4'd2;
    localparam logic [3:0] S_SWP  = 4'd3;
    localparam logic [3:0] S_LOOP = 4'd4;
    localparam logic [3:0] S_LEV  = 4'd5;
    localparam logic [3:0] S_NEX  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_ORD  = 4'd8;
    localparam logic [3:0] S_OLD  = 4'd9;
    localparam logic [3:0] S_OSND = 4'd10;

    // per-channel state
    logic [2:0]    r_c_st   [0:NUM_CHANNELS-1];
    logic [7:0]    r_c_dl   [0:NUM_CHANNELS-1];
    logic [7:0]    r_c_pr   [0:NUM_CHANNELS-1];
    logic [2:0]    r_c_rem  [0:NUM_CHANNELS-1];
    logic [SW-1:0] r_c_slot [0:NUM_CHANNELS-1];
    logic          r_c_has  [0:NUM_CHANNELS-1];
    logic [15:0]   r_c_fr   [0:NUM_CHANNELS-1];
    logic [15:0]   r_c_pw   [0:NUM_CHANNELS-1];

    // working copy of the addressed channel
    logic [2:0]    r_st;
    logic [7:0]    r_dl;
    logic [7:0]    r_pr;
    logic [2:0]    r_rem;
    logic [SW-1:0] r_slot;
    logic          r_has;
    logic [15:0]   r_fr;
    logic [15:0]   r_pw;

    // item and sequencing registers
    logic [3:0]    r_state;
    logic [2:0]    r_act;
    logic [1:0]    r_chan;
    logic          r_vld;
    logic [SW-1:0] r_islot;
    logic [3:0]    r_cnt;
    logic [6:0]    r_guard;
    logic [2:0]    r_ec;
    logic [7:0]    r_sr;
    logic [6:0]    r_nres;
    logic [6:0]    r_k;
    logic          r_idle;
    logic [2:0]    r_orem;
    logic          r_ovalid;
    logic [23:0]   r_otdata;
    logic [2:0]    r_ouser;
    logic          r_olast;

    // input fields
    logic [1:0]    in_chan;
    logic [5:0]    in_idx;
    logic [3:0]    in_cnt;
    t_entry        in_data;
    logic [2:0]    in_act;
    logic          in_vld;
    logic [CW-1:0] in_ci;
    logic [6:0]    idx_red;
    logic [SW-1:0] in_slot;
    logic          accept;

    assign in_chan = i_s_axis_tdata[1:0];
    assign in_idx  = i_s_axis_tdata[7:2];
    assign in_cnt  = i_s_axis_tdata[11:8];
    assign in_data = i_s_axis_tdata[67:12];
    assign in_act  = i_s_axis_tuser;
    assign in_vld  = 32'(in_chan) < NUM_CHANNELS;
    assign in_ci   = in_vld ? CW'(in_chan) : '0;
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;

    // entry index reduced into the store range
    always_comb begin
        idx_red = {1'b0, in_idx};
        for (int i = 0; i < 8; i++) begin
            if (idx_red >= 7'(EFFECT_SLOTS)) begin
                idx_red = idx_red - 7'(EFFECT_SLOTS);
            end
        end
    end
    assign in_slot = SW'(idx_red);

    // entry memories
    t_entry        lo_rd;
    t_entry        hi_rd;
    logic          ent_re;
    logic [SW-1:0] ent_raddr;
    logic [SW-1:0] slot_nx;
    logic          need_n;
    logic          loop_go;

    assign slot_nx = (r_slot == SW'(EFFECT_SLOTS - 1)) ? '0 : r_slot + 1'b1;
    assign loop_go = (r_dl == 8'd0) && (r_guard < 7'd64);

    // entry fields of the current read
    logic [7:0]  e_ctrl;
    logic [7:0]  e_t0;
    logic [7:0]  e_t1;
    logic [15:0] e_df;
    logic [15:0] e_dp;
    logic        nx_trig;

    assign e_ctrl = lo_rd[39:32];
    assign e_t0   = hi_rd[47:40];
    assign e_t1   = hi_rd[39:32];
    assign e_df   = hi_rd[15:0];
    assign e_dp   = hi_rd[31:16];

    assign need_n = (r_state == S_LEV) && (r_rem != 3'd0) &&
                    ((r_st == ST_PLAY && e_t0 == 8'd0) || r_st == ST_WAIT);

    // gate retrigger when the next entry starts with a higher sustain
    assign nx_trig = (r_st == ST_PLAY) && ((lo_rd[47:40] & ATTDEC_MASK) == 8'd0) &&
                     lo_rd[32] && ((lo_rd[55:48] & SUSREL_HI) > r_sr);

    // entry read address
    always_comb begin
        ent_re    = 1'b0;
        ent_raddr = r_slot;
        if (accept) begin
            ent_re    = 1'b1;
            ent_raddr = (in_act == ACT_PLAY) ? in_slot : r_c_slot[in_ci];
        end else if (r_state == S_LOOP && loop_go) begin
            ent_re    = 1'b1;
            ent_raddr = r_slot;
        end else if (need_n) begin
            ent_re    = 1'b1;
            ent_raddr = slot_nx;
        end
    end

    sevs_ram #(.WIDTH(ENTRY_W), .DEPTH(EFFECT_SLOTS)) u_lo_ram (
        .i_clk   (i_clk),
        .i_we    (accept && in_act == ACT_WR_LO),
        .i_waddr (in_slot),
        .i_wdata (in_data),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (lo_rd)
    );

    sevs_ram #(.WIDTH(ENTRY_W), .DEPTH(EFFECT_SLOTS)) u_hi_ram (
        .i_clk   (i_clk),
        .i_we    (accept && in_act == ACT_WR_HI),
        .i_waddr (in_slot),
        .i_wdata (in_data),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (hi_rd)
    );

    // register write produced in the current cycle
    logic        em_en;
    logic [2:0]  em_reg;
    logic [15:0] em_val;

    always_comb begin
        em_en  = 1'b0;
        em_reg = REG_STATUS;
        em_val = 16'd0;
        case (r_state)
            S_SWF: begin
                em_en  = e_df != 16'd0;
                em_reg = REG_FREQ;
                em_val = r_fr + e_df;
            end
            S_SWP: begin
                em_en  = e_dp != 16'd0;
                em_reg = REG_PWM;
                em_val = r_pw + e_dp;
            end
            S_LEV: begin
                case (r_st)
                    ST_RESET: begin
                        em_en  = 1'b1;
                        em_reg = (r_ec == 3'd0) ? REG_CTRL :
                                 (r_ec == 3'd1) ? REG_ATTDEC : REG_SUSREL;
                    end
                    ST_READY: begin
                        em_en = 1'b1;
                        case (r_ec)
                            3'd0: begin
                                em_reg = REG_FREQ;
                                em_val = lo_rd[15:0];
                            end
                            3'd1: begin
                                em_reg = REG_PWM;
                                em_val = lo_rd[31:16];
                            end
                            3'd2: begin
                                em_reg = REG_ATTDEC;
                                em_val = {8'd0, lo_rd[47:40]};
                            end
                            3'd3: begin
                                em_reg = REG_SUSREL;
                                em_val = {8'd0, lo_rd[55:48]};
                            end
                            default: begin
                                em_reg = REG_CTRL;
                                em_val = {8'd0, e_ctrl};
                            end
                        endcase
                    end
                    ST_PLAY: begin
                        em_en  = e_t0 != 8'd0;
                        em_reg = REG_CTRL;
                        em_val = {8'd0, e_ctrl & ~CTRL_GATE};
                    end
                    default: begin
                        em_en = 1'b0;
                    end
                endcase
            end
            S_NEX: begin
                em_en  = nx_trig;
                em_reg = REG_CTRL;
                em_val = (r_ec == 3'd0) ? {8'd0, e_ctrl & ~CTRL_GATE} :
                                          {8'd0, e_ctrl | CTRL_GATE};
            end
            S_FIN: begin
                em_en = r_nres == 7'd0;
            end
            default: begin
                em_en = 1'b0;
            end
        endcase
    end

    // result memory
    logic             res_we;
    logic [RES_W-1:0] res_rd;

    assign res_we = em_en && (r_nres < 7'(MAX_RESULTS));

    sevs_ram #(.WIDTH(RES_W), .DEPTH(MAX_RESULTS)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (r_nres[RES_AW-1:0]),
        .i_wdata ({em_reg, em_val}),
        .i_re    (r_state == S_ORD),
        .i_raddr (r_k[RES_AW-1:0]),
        .o_rdata (res_rd)
    );

    // play count clamp
    logic [3:0] cnt_eff;
    logic [7:0] play_pr;
    assign cnt_eff = (r_cnt == 4'd0) ? 4'd1 :
                     (r_cnt > 4'(MAX_CHAIN)) ? 4'(MAX_CHAIN) : r_cnt;
    assign play_pr = hi_rd[55:48];

    logic [CW-1:0] r_ci;
    assign r_ci = CW'(r_chan);

    logic [7:0] dl_dec;
    assign dl_dec = r_dl - 8'd1;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_nres   <= '0;
            r_guard  <= '0;
            r_ec     <= '0;
            r_k      <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_c_st[c]   <= ST_IDLE;
                r_c_dl[c]   <= 8'd1;
                r_c_pr[c]   <= '0;
                r_c_rem[c]  <= '0;
                r_c_slot[c] <= '0;
                r_c_has[c]  <= 1'b0;
                r_c_fr[c]   <= '0;
                r_c_pw[c]   <= '0;
            end
        end else begin
            if (res_we) begin
                r_nres <= r_nres + 7'd1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_act   <= in_act;
                        r_chan  <= in_chan;
                        r_vld   <= in_vld;
                        r_islot <= in_slot;
                        r_cnt   <= in_cnt;
                        r_st    <= r_c_st[in_ci];
                        r_dl    <= r_c_dl[in_ci];
                        r_pr    <= r_c_pr[in_ci];
                        r_rem   <= r_c_rem[in_ci];
                        r_slot  <= r_c_slot[in_ci];
                        r_has   <= r_c_has[in_ci];
                        r_fr    <= r_c_fr[in_ci];
                        r_pw    <= r_c_pw[in_ci];
                        r_nres  <= '0;
                        r_guard <= '0;
                        r_ec    <= '0;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_state <= S_FIN;
                    if (r_vld) begin
                        case (r_act)
                            ACT_TICK: begin
                                if (r_st != ST_IDLE) begin
                                    r_dl    <= dl_dec;
                                    r_state <= (dl_dec != 8'd0 && r_has) ? S_SWF : S_LOOP;
                                end
                            end
                            ACT_PLAY: begin
                                if (r_st == ST_IDLE || r_pr <= play_pr) begin
                                    r_st   <= (r_st == ST_IDLE) ? ST_READY : ST_RESET;
                                    r_dl   <= 8'd1;
                                    r_slot <= r_islot;
                                    r_has  <= 1'b1;
                                    r_rem  <= 3'(cnt_eff - 4'd1);
                                    r_pr   <= play_pr;
                                end
                            end
                            ACT_STOP: begin
                                r_has <= 1'b0;
                                if (r_st != ST_IDLE) begin
                                    r_st <= ST_RESET;
                                    r_dl <= 8'd1;
                                end
                            end
                            default: begin
                                r_has <= r_has;
                            end
                        endcase
                    end
                end
                S_SWF: begin
                    r_fr    <= r_fr + e_df;
                    r_state <= S_SWP;
                end
                S_SWP: begin
                    r_pw    <= r_pw + e_dp;
                    r_state <= S_LOOP;
                end
                S_LOOP: begin
                    if (loop_go) begin
                        r_guard <= r_guard + 7'd1;
                        r_state <= S_LEV;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_LEV: begin
                    case (r_st)
                        ST_RESET: begin
                            if (r_ec == 3'd2) begin
                                r_ec    <= '0;
                                r_st    <= r_has ? ST_READY : ST_IDLE;
                                r_dl    <= 8'd1;
                                r_state <= S_LOOP;
                            end else begin
                                r_ec <= r_ec + 3'd1;
                            end
                        end
                        ST_READY: begin
                            if (r_ec == 3'd0) begin
                                r_fr <= lo_rd[15:0];
                            end
                            if (r_ec == 3'd1) begin
                                r_pw <= lo_rd[31:16];
                            end
                            if (r_ec == 3'd4) begin
                                r_ec    <= '0;
                                r_dl    <= e_ctrl[0] ? e_t1 : e_t0;
                                r_st    <= ST_PLAY;
                                r_state <= S_LOOP;
                            end else begin
                                r_ec <= r_ec + 3'd1;
                            end
                        end
                        ST_PLAY: begin
                            if (e_t0 != 8'd0) begin
                                r_dl    <= e_t0 - 8'd1;
                                r_st    <= ST_WAIT;
                                r_state <= S_LOOP;
                            end else if (r_rem != 3'd0) begin
                                r_sr    <= lo_rd[55:48] & SUSREL_HI;
                                r_state <= S_NEX;
                            end else begin
                                r_has   <= 1'b0;
                                r_st    <= ST_RESET;
                                r_state <= S_LOOP;
                            end
                        end
                        ST_WAIT: begin
                            if (r_rem != 3'd0) begin
                                r_state <= S_NEX;
                            end else begin
                                r_has   <= 1'b0;
                                r_st    <= ST_RESET;
                                r_state <= S_LOOP;
                            end
                        end
                        default: begin
                            r_st    <= ST_IDLE;
                            r_dl    <= 8'd1;
                            r_state <= S_LOOP;
                        end
                    endcase
                end
                S_NEX: begin
                    if (!nx_trig || r_ec == 3'd1) begin
                        r_ec    <= '0;
                        r_rem   <= r_rem - 3'd1;
                        r_slot  <= slot_nx;
                        r_pr    <= hi_rd[55:48];
                        r_st    <= (r_st == ST_WAIT && lo_rd[32]) ? ST_RESET : ST_READY;
                        r_state <= S_LOOP;
                    end else begin
                        r_ec <= r_ec + 3'd1;
                    end
                end
                S_FIN: begin
                    r_idle <= r_vld ? (r_st == ST_IDLE) : 1'b1;
                    r_orem <= r_vld ? r_rem : 3'd0;
                    if (r_vld) begin
                        r_c_st[r_ci]   <= r_st;
                        r_c_dl[r_ci]   <= r_dl;
                        r_c_pr[r_ci]   <= r_pr;
                        r_c_rem[r_ci]  <= r_rem;
                        r_c_slot[r_ci] <= r_slot;
                        r_c_has[r_ci]  <= r_has;
                        r_c_fr[r_ci]   <= r_fr;
                        r_c_pw[r_ci]   <= r_pw;
                    end
                    r_k     <= '0;
                    r_state <= S_ORD;
                end
                S_ORD: begin
                    r_state <= S_OLD;
                end
                S_OLD: begin
                    r_ovalid <= 1'b1;
                    r_otdata <= {2'b00, r_orem, r_idle, res_rd[15:0], r_chan};
                    r_ouser  <= res_rd[18:16];
                    r_olast  <= (r_k + 7'd1) == r_nres;
                    r_state  <= S_OSND;
                end
                S_OSND: begin
                    if (i_m_axis_tready) begin
                        r_ovalid <= 1'b0;
                        r_k      <= r_k + 7'd1;
                        r_state  <= r_olast ? S_IDLE : S_ORD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = r_state == S_IDLE;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_otdata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    // a result is only shown while the send state waits for the transfer
    a_ovalid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_state == S_OSND)
        else $error("output valid outside send state");

    // the result count stays within the result memory
    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= 7'(MAX_RESULTS))
        else $error("result count overflow");

    // the chain walk never runs past its guard
    a_guard_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_guard <= 7'd64)
        else $error("chain guard overflow");

    // every item sends at least one result before the next is taken
    a_fin_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |=> r_nres != 7'd0)
        else $error("item finished without a result");
`endif

endmodule

[dv/sound_effect_voice_sequencer_unit_tb.sv]
`timescale 1ns / 100ps

module sound_effect_voice_sequencer_unit_tb;
    import sevs_pkg::*;

    localparam int NCH        = 3;
    localparam int SLOTS      = 64;
    localparam int CHAIN_MAX  = 8;
    localparam int CYCLE_CAP  = 2000000;
    localparam int RAND_ITEMS = 70;
    localparam int SETTLE     = 60;
    // action codes the block does not define
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [1:0]  voice;
        logic [2:0]  regsel;
        logic [15:0] value;
        logic        idle;
        logic [2:0]  rem;
        logic        last;
    } t_voice_write;

    typedef struct packed {
        logic [2:0]  regsel;
        logic [15:0] value;
    } t_reg_write;

    typedef struct {
        logic [2:0]  action;
        logic [1:0]  ch;
        logic [5:0]  idx;
        logic [3:0]  cnt;
        logic [55:0] data;
        bit          typed;
        logic [2:0]  t_reg;
        logic [15:0] t_val;
        logic        t_idle;
        logic [2:0]  t_rem;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    sound_effect_voice_sequencer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the store and channel state
    logic [55:0] lo_mem [SLOTS];
    logic [55:0] hi_mem [SLOTS];
    logic [2:0]  p_state [NCH];
    logic [7:0]  p_delay [NCH];
    logic [7:0]  p_prio [NCH];
    logic [2:0]  p_rem [NCH];
    logic [5:0]  p_slot [NCH];
    logic        p_has [NCH];
    logic [15:0] p_freq [NCH];
    logic [15:0] p_pwm [NCH];

    t_voice_write pending_writes [$];
    t_reg_write   item_writes [$];
    int           mismatches = 0;
    int           checked = 0;
    int           sent = 0;
    int           cycles = 0;
    bit           send_calm = 1'b0;
    bit           recv_calm = 1'b0;

    // register write produced while predicting one item
    function automatic void note_write(logic [2:0] r, logic [15:0] v);
        if (item_writes.size() < MAX_RESULTS) item_writes.push_back({r, v});
    endfunction

    // one tick of channel c: delay, sweeps, then state chain
    function automatic void advance_channel(int c);
        logic [5:0]  s, n;
        logic [7:0]  ctrl, t0, sr, nctrl;
        logic [15:0] df, dp;
        if (p_state[c] == ST_IDLE) return;
        p_delay[c] = p_delay[c] - 8'd1;
        s = p_slot[c];
        if (p_delay[c] != 0 && p_has[c]) begin
            df = hi_mem[s][15:0];
            dp = hi_mem[s][31:16];
            if (df != 0) begin
                p_freq[c] = p_freq[c] + df;
                note_write(REG_FREQ, p_freq[c]);
            end
            if (dp != 0) begin
                p_pwm[c] = p_pwm[c] + dp;
                note_write(REG_PWM, p_pwm[c]);
            end
        end
        for (int g = 0; g < 64 && p_delay[c] == 0; g++) begin
            s = p_slot[c];
            ctrl = lo_mem[s][39:32];
            t0 = hi_mem[s][47:40];
            case (p_state[c])
                ST_RESET: begin
                    note_write(REG_CTRL, 16'd0);
                    note_write(REG_ATTDEC, 16'd0);
                    note_write(REG_SUSREL, 16'd0);
                    p_state[c] = p_has[c] ? ST_READY : ST_IDLE;
                    p_delay[c] = 8'd1;
                end
                ST_READY: begin
                    p_freq[c] = lo_mem[s][15:0];
                    p_pwm[c] = lo_mem[s][31:16];
                    note_write(REG_FREQ, p_freq[c]);
                    note_write(REG_PWM, p_pwm[c]);
                    note_write(REG_ATTDEC, {8'd0, lo_mem[s][47:40]});
                    note_write(REG_SUSREL, {8'd0, lo_mem[s][55:48]});
                    note_write(REG_CTRL, {8'd0, ctrl});
                    p_delay[c] = (ctrl & CTRL_GATE) != 0 ? hi_mem[s][39:32] : t0;
                    p_state[c] = ST_PLAY;
                end
                ST_PLAY: begin
                    if (t0 != 0) begin
                        note_write(REG_CTRL, {8'd0, ctrl & ~CTRL_GATE});
                        p_delay[c] = t0 - 8'd1;
                        p_state[c] = ST_WAIT;
                    end else if (p_rem[c] != 0) begin
                        sr = lo_mem[s][55:48] & SUSREL_HI;
                        n = s + 6'd1;
                        nctrl = lo_mem[n][39:32];
                        // gate retrigger into the next entry
                        if ((lo_mem[n][47:40] & ATTDEC_MASK) == 0 && (nctrl & CTRL_GATE) != 0 &&
                            (lo_mem[n][55:48] & SUSREL_HI) > sr) begin
                            note_write(REG_CTRL, {8'd0, nctrl & ~CTRL_GATE});
                            note_write(REG_CTRL, {8'd0, nctrl | CTRL_GATE});
                        end
                        p_rem[c] = p_rem[c] - 3'd1;
                        p_slot[c] = n;
                        p_prio[c] = hi_mem[n][55:48];
                        p_state[c] = ST_READY;
                    end else begin
                        p_has[c] = 1'b0;
                        p_state[c] = ST_RESET;
                    end
                end
                ST_WAIT: begin
                    if (p_rem[c] != 0) begin
                        n = s + 6'd1;
                        p_rem[c] = p_rem[c] - 3'd1;
                        p_slot[c] = n;
                        p_prio[c] = hi_mem[n][55:48];
                        p_state[c] = (lo_mem[n][39:32] & CTRL_GATE) != 0 ? ST_RESET : ST_READY;
                    end else begin
                        p_has[c] = 1'b0;
                        p_state[c] = ST_RESET;
                    end
                end
                default: begin
                    p_state[c] = ST_IDLE;
                    p_delay[c] = 8'd1;
                end
            endcase
        end
    endfunction

    // start a chain on channel c unless a higher priority effect runs
    function automatic void start_chain(int c, logic [5:0] s, logic [3:0] cnt);
        logic [7:0] pr;
        logic [2:0] ns;
        int         n;
        pr = hi_mem[s][55:48];
        n = cnt;
        if (n == 0) n = 1;
        if (n > CHAIN_MAX) n = CHAIN_MAX;
        if (p_state[c] == ST_IDLE) ns = ST_READY;
        else if (p_prio[c] <= pr) ns = ST_RESET;
        else return;
        p_delay[c] = 8'd1;
        p_slot[c] = s;
        p_has[c] = 1'b1;
        p_rem[c] = 3'(n - 1);
        p_prio[c] = pr;
        p_state[c] = ns;
    endfunction

    // expected voice writes of one accepted item
    function automatic void predict_writes(logic [2:0] act, logic [1:0] ch, logic [5:0] idx,
                                           logic [3:0] cnt, logic [55:0] data);
        bit         ok;
        logic       idle;
        logic [2:0] rem;
        ok = ch < NCH;
        item_writes.delete();
        case (act)
            ACT_TICK:  if (ok) advance_channel(ch);
            ACT_PLAY:  if (ok) start_chain(ch, idx, cnt);
            ACT_STOP: begin
                if (ok) begin
                    p_has[ch] = 1'b0;
                    if (p_state[ch] != ST_IDLE) begin
                        p_state[ch] = ST_RESET;
                        p_delay[ch] = 8'd1;
                    end
                end
            end
            ACT_WR_LO: lo_mem[idx] = data;
            ACT_WR_HI: hi_mem[idx] = data;
            default: ;
        endcase
        if (item_writes.size() == 0) note_write(REG_STATUS, 16'd0);
        idle = 1'b1;
        rem = 3'd0;
        if (ok) begin
            idle = p_state[ch] == ST_IDLE;
            rem = p_rem[ch];
        end
        foreach (item_writes[k])
            pending_writes.push_back({ch, item_writes[k].regsel, item_writes[k].value, idle, rem,
                                      k == item_writes.size() - 1});
    endfunction

    // one input transfer with a random gap before it
    task automatic send_item(t_stim_row row);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tdata = {4'd0, row.data, row.cnt, row.idx, row.ch};
        s_tuser = row.action;
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        predict_writes(row.action, row.ch, row.idx, row.cnt, row.data);
        if (row.typed) begin
            pending_writes.pop_back();
            pending_writes.push_back({row.ch, row.t_reg, row.t_val, row.t_idle, row.t_rem, 1'b1});
        end
        sent++;
        if (sent % 37 == 0) send_calm = $urandom_range(0, 2) == 0;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        while (pending_writes.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_stim_row make_row(logic [2:0] a, logic [1:0] c, logic [5:0] i,
                                           logic [3:0] n, logic [55:0] d);
        t_stim_row r;
        r = '{a, c, i, n, d, 1'b0, REG_STATUS, 16'd0, 1'b1, 3'd0};
        return r;
    endfunction

    // a status-only row whose answer is fixed
    function automatic t_stim_row status_row(logic [2:0] a, logic [1:0] c, logic [55:0] d,
                                             logic [5:0] i);
        t_stim_row r;
        r = make_row(a, c, i, 4'd1, d);
        r.typed = 1'b1;
        return r;
    endfunction

    // high word with short times so chains move along
    function automatic logic [55:0] short_high_word();
        logic [55:0] w;
        w = 56'({$urandom, $urandom});
        w[39:32] = 8'($urandom_range(0, 3));
        w[47:40] = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 2) == 0) w[15:0] = 16'd0;
        if ($urandom_range(0, 2) == 0) w[31:16] = 16'd0;
        if ($urandom_range(0, 9) == 0) w[47:32] = 16'($urandom);
        return w;
    endfunction

    function automatic logic [55:0] random_low_word();
        logic [55:0] w;
        w = 56'({$urandom, $urandom});
        if ($urandom_range(0, 2) == 0) w[47:40] = w[47:40] & ~ATTDEC_MASK;
        return w;
    endfunction

    // output checker with random stalls
    initial begin : result_sink
        int gap;
        t_voice_write exp_w;
        t_voice_write got;
        @(posedge i_rst_n);
        forever begin
            gap = recv_calm ? 0 : $urandom_range(0, 9);
            m_tready = 1'b0;
            repeat (gap) @(negedge i_clk);
            m_tready = 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            got = {m_tdata[1:0], m_tuser, m_tdata[17:2], m_tdata[18], m_tdata[21:19], m_tlast};
            if (pending_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %h", got);
            end else begin
                exp_w = pending_writes.pop_front();
                checked++;
                if (got !== exp_w) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch %0d: exp v%0d r%0d %h i%0d n%0d l%0d, %s",
                                 checked, exp_w.voice, exp_w.regsel, exp_w.value, exp_w.idle,
                                 exp_w.rem, exp_w.last,
                                 $sformatf("got v%0d r%0d %h i%0d n%0d l%0d", got.voice,
                                           got.regsel, got.value, got.idle, got.rem,
                                           got.last));
                end
            end
            if (checked % 53 == 0) recv_calm = $urandom_range(0, 2) == 0;
            @(negedge i_clk);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        t_stim_row   table_rows [$];
        t_stim_row   r;
        int          pick;
        logic [55:0] ones;
        ones = '1;
        for (int c = 0; c < NCH; c++) begin
            p_state[c] = ST_IDLE;
            p_delay[c] = 8'd1;
            p_prio[c] = 8'd0;
            p_rem[c] = 3'd0;
            p_slot[c] = 6'd0;
            p_has[c] = 1'b0;
            p_freq[c] = 16'd0;
            p_pwm[c] = 16'd0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // fill the whole store so no slot is read unwritten
        for (int s = 0; s < SLOTS; s++) begin
            send_item(make_row(ACT_WR_LO, 2'($urandom_range(0, 3)), 6'(s), 4'($urandom),
                               random_low_word()));
            send_item(make_row(ACT_WR_HI, 2'($urandom_range(0, 3)), 6'(s), 4'($urandom),
                               short_high_word()));
        end

        // directed table
        table_rows.push_back(status_row(ACT_SPARE_LO, 2'd0, ones, 6'd0));
        table_rows.push_back(status_row(ACT_SPARE_HI, 2'd3, '0, 6'd63));
        table_rows.push_back(status_row(ACT_TICK, 2'd0, '0, 6'd0));
        table_rows.push_back(status_row(ACT_STOP, 2'd1, '0, 6'd0));
        table_rows.push_back(status_row(ACT_PLAY, 2'd3, '0, 6'd5));
        table_rows.push_back(status_row(ACT_TICK, 2'd3, '0, 6'd0));
        table_rows.push_back(status_row(ACT_STOP, 2'd3, '0, 6'd0));
        table_rows.push_back(status_row(ACT_WR_LO, 2'd2, ones, 6'd63));
        table_rows.push_back(status_row(ACT_WR_HI, 2'd2, 56'h01_02_01_ffff_ffff, 6'd63));
        table_rows.push_back(status_row(ACT_WR_LO, 2'd0, '0, 6'd0));
        table_rows.push_back(status_row(ACT_WR_HI, 2'd0, '0, 6'd0));
        // gate retrigger pair with zero times and rising sustain
        table_rows.push_back(status_row(ACT_WR_LO, 2'd0, 56'h20_00_41_1234_5678, 6'd10));
        table_rows.push_back(status_row(ACT_WR_HI, 2'd0, 56'h05_00_00_0000_0000, 6'd10));
        table_rows.push_back(status_row(ACT_WR_LO, 2'd0, 56'hf0_10_41_0800_4000, 6'd11));
        table_rows.push_back(status_row(ACT_WR_HI, 2'd0, 56'h05_02_00_0001_0100, 6'd11));
        // count zero, count above chain limit wrapping past the store end
        table_rows.push_back(make_row(ACT_PLAY, 2'd0, 6'd63, 4'd0, '0));
        table_rows.push_back(make_row(ACT_PLAY, 2'd1, 6'd62, 4'd15, ones));
        table_rows.push_back(make_row(ACT_PLAY, 2'd2, 6'd10, 4'd2, '0));
        table_rows.push_back(make_row(ACT_TICK, 2'd2, 6'd0, 4'd0, '0));
        table_rows.push_back(make_row(ACT_TICK, 2'd0, 6'd0, 4'd0, '0));
        table_rows.push_back(make_row(ACT_TICK, 2'd0, 6'd0, 4'd0, '0));
        table_rows.push_back(make_row(ACT_TICK, 2'd1, 6'd0, 4'd0, '0));
        table_rows.push_back(make_row(ACT_PLAY, 2'd1, 6'd0, 4'd8, '0));
        table_rows.push_back(make_row(ACT_STOP, 2'd0, 6'd0, 4'd0, '0));
        table_rows.push_back(make_row(ACT_TICK, 2'd0, 6'd0, 4'd0, '0));
        foreach (table_rows[k]) send_item(table_rows[k]);

        // hold off until every result of the directed part is back
        s_tvalid = 1'b0;
        drain_results();

        // random part: mostly ticks on live channels, plays, writes, some noise
        for (int k = 0; k < RAND_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            r = make_row(ACT_TICK, 2'($urandom_range(0, 2)), 6'($urandom), 4'($urandom),
                         56'({$urandom, $urandom}));
            if (pick < 60) r.action = ACT_TICK;
            else if (pick < 74) r.action = ACT_PLAY;
            else if (pick < 79) r.action = ACT_STOP;
            else if (pick < 86) begin
                r.action = ACT_WR_LO;
                r.data = random_low_word();
            end else if (pick < 93) begin
                r.action = ACT_WR_HI;
                r.data = short_high_word();
            end else if (pick < 97) begin
                r.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
                r.ch = 2'($urandom_range(0, 3));
            end else r.ch = 2'd3;
            if (k == RAND_ITEMS / 2) begin
                s_tvalid = 1'b0;
                drain_results();
            end
            send_item(r);
        end
        s_tvalid = 1'b0;

        drain_results();
        repeat (SETTLE) @(negedge i_clk);
        $display("sent %0d items (store fill, directed table, random mix of tick/play/stop/write)",
                 sent);
        $display("compared %0d voice register writes, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && pending_writes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
